@@ rtl/bpglm_pkg.sv @@
package bpglm_pkg;

	localparam int COLS_DEF     = 8;
	localparam int ROWS_DEF     = 8;
	localparam int PLANE_STRIDE = 8;
	localparam int LEVEL_W      = 8;
	localparam int PLANE_W      = 3;
	localparam int LAMP_W       = 64;
	localparam int POS_W        = 3;
	localparam int OP_W         = 2;
	localparam int TICK_W       = 8;

	localparam logic [OP_W-1:0] OP_WRITE   = 2'd0;
	localparam logic [OP_W-1:0] OP_TICK    = 2'd1;
	localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

	localparam logic [TICK_W-1:0] TICK_LAST = 8'hFF;

	typedef logic [OP_W-1:0]    op_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [LEVEL_W-1:0] level_t;
	typedef logic [PLANE_W-1:0] plane_t;
	typedef logic [LAMP_W-1:0]  lamp_bits_t;
	typedef logic [TICK_W-1:0]  tick_t;

	typedef struct packed {
		logic   we;
		pos_t   col;
		pos_t   row;
		level_t level;
	} lamp_wr_t;

	typedef struct packed {
		plane_t plane;
		logic   wrap;
	} tick_info_t;

	// Bit plane shown at tick t: floor(log2(t+1)), and plane 0 on the last tick.
	function automatic plane_t plane_of(input tick_t t);
		tick_t  n;
		plane_t p;
		n = t + tick_t'(1);
		p = '0;
		if (t != TICK_LAST) begin
			for (int i = 0; i < TICK_W; i++) begin
				if (n[i]) begin
					p = plane_t'(i);
				end
			end
		end
		return p;
	endfunction

endpackage

@@ rtl/bpglm_cmd_if.sv @@
interface bpglm_cmd_if import bpglm_pkg::*; ();
	logic   valid;
	logic   ready;
	op_t    op;
	pos_t   col;
	pos_t   row;
	level_t level;

	modport source (output valid, output op, output col, output row, output level, input ready);
	modport sink (input valid, input op, input col, input row, input level, output ready);
endinterface

@@ rtl/bpglm_res_if.sv @@
interface bpglm_res_if import bpglm_pkg::*; ();
	logic       valid;
	logic       ready;
	lamp_bits_t lamp_bits;
	plane_t     plane;
	logic       frame_start;

	modport source (output valid, output lamp_bits, output plane, output frame_start,
		input ready);
	modport sink (input valid, input lamp_bits, input plane, input frame_start,
		output ready);
endinterface

@@ rtl/bpglm_lamp_store.sv @@
module bpglm_lamp_store import bpglm_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  lamp_wr_t   wr,
	input  plane_t     plane,
	output lamp_bits_t bits
);

	logic [COLS*ROWS-1:0] hit;

	// One level register per lamp, written at a fixed cell by address match.
	for (genvar c = 0; c < COLS; c++) begin : g_col
		for (genvar r = 0; r < ROWS; r++) begin : g_row
			level_t lvl_q;

			assign hit[c*ROWS+r] = wr.we && (wr.col == pos_t'(c)) && (wr.row == pos_t'(r));

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					lvl_q <= '0;
				end else if (hit[c*ROWS+r]) begin
					lvl_q <= wr.level;
				end
			end

			// Pick the bit of the shown plane for this lamp.
			assign bits[c*PLANE_STRIDE+r] = lvl_q[plane];
		end
	end

	// Lamps outside the matrix stay dark.
	for (genvar i = 0; i < LAMP_W; i++) begin : g_pad
		if ((i % PLANE_STRIDE) >= ROWS || (i / PLANE_STRIDE) >= COLS) begin : g_off
			assign bits[i] = 1'b0;
		end
	end

endmodule

@@ rtl/bpglm_tick_ctr.sv @@
module bpglm_tick_ctr import bpglm_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       tick_en,
	input  logic       restart_en,
	input  logic       is_tick,
	output tick_info_t info
);

	tick_t tick_q;
	tick_t next_c;

	// Next count for the word in stage 1: advance on a tick, zero on restart.
	assign next_c     = is_tick ? tick_q + tick_t'(1) : '0;
	assign info.plane = plane_of(next_c);
	assign info.wrap  = is_tick && (next_c == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= '0;
		end else if (tick_en || restart_en) begin
			tick_q <= next_c;
		end
	end

endmodule

@@ rtl/bit_plane_greyscale_lamp_modulator_unit.sv @@
// Binary code modulation driver for an 8x8 lamp matrix, 8-bit greyscale.
// Throughput: one command word per cycle, sustained, while results are taken.
// A tick or restart word passes the input register, then the result register, before it
// shows on res; a lamp write lands in the store when its word retires from stage 1.
// Reset (arst_n low, asynchronous): all lamp levels, the tick counter and
// both valid flags clear at once; no clearing pass is needed.
module bit_plane_greyscale_lamp_modulator_unit import bpglm_pkg::*; #(
	parameter int COLS = COLS_DEF,
	parameter int ROWS = ROWS_DEF
) (
	input logic          clk,
	input logic          arst_n,
	bpglm_cmd_if.sink    cmd,
	bpglm_res_if.source  res
);

	// Stage 1: registered command word.
	logic   valid_s1;
	op_t    op_s1;
	pos_t   col_s1;
	pos_t   row_s1;
	level_t level_s1;

	// Result register.
	logic       out_valid_q;
	lamp_bits_t lamp_bits_q;
	plane_t     plane_q;
	logic       frame_start_q;

	logic       has_res;
	logic       out_free;
	logic       adv;
	lamp_wr_t   wr;
	tick_info_t info;
	lamp_bits_t bits;

	// Tick and restart words make a result; writes and the unused code do not.
	assign has_res  = (op_s1 == OP_TICK) || (op_s1 == OP_RESTART);
	// The result register is free when empty or being drained this cycle.
	assign out_free = !out_valid_q || res.ready;
	// Stage 1 retires its word unless a result must wait for the register.
	assign adv      = valid_s1 && (!has_res || out_free);
	assign cmd.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.ready) begin
			valid_s1 <= cmd.valid;
		end
	end

	// Payload of stage 1: load on accept, hold otherwise.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			op_s1    <= cmd.op;
			col_s1   <= cmd.col;
			row_s1   <= cmd.row;
			level_s1 <= cmd.level;
		end
	end

	// Writes land in the store as they retire, so a tick right behind sees them.
	assign wr.we    = adv && (op_s1 == OP_WRITE);
	assign wr.col   = col_s1;
	assign wr.row   = row_s1;
	assign wr.level = level_s1;

	bpglm_tick_ctr u_tick (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick_en    (adv && (op_s1 == OP_TICK)),
		.restart_en (adv && (op_s1 == OP_RESTART)),
		.is_tick    (op_s1 == OP_TICK),
		.info       (info)
	);

	bpglm_lamp_store #(
		.COLS (COLS),
		.ROWS (ROWS)
	) u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (wr),
		.plane  (info.plane),
		.bits   (bits)
	);

	// Result register: load a new word on retire, drop it once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && has_res) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && has_res) begin
			lamp_bits_q   <= bits;
			plane_q       <= info.plane;
			frame_start_q <= info.wrap;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.lamp_bits   = lamp_bits_q;
	assign res.plane       = plane_q;
	assign res.frame_start = frame_start_q;

endmodule

@@ rtl/bpglm_checker.sv @@
module bpglm_checker import bpglm_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       cmd_valid,
	input logic       cmd_ready,
	input logic       res_valid,
	input logic       res_ready,
	input lamp_bits_t lamp_bits,
	input plane_t     plane,
	input logic       frame_start
);

	// A stalled result word holds.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(lamp_bits) && $stable(plane)
			&& $stable(frame_start))
		else $error("result word changed while stalled");

	// A frame wrap always shows plane 0.
	a_wrap_plane: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_start |-> plane == '0)
		else $error("frame start with nonzero plane");

	// Input backpressure only comes from a stalled full result register.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> res_valid && !res_ready)
		else $error("command stalled without a stalled result");

	// The command side is always ready while the result side is idle.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> cmd_ready)
		else $error("command not ready while result side idle");

endmodule

bind bit_plane_greyscale_lamp_modulator_unit bpglm_checker u_bpglm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cmd_valid   (cmd.valid),
	.cmd_ready   (cmd.ready),
	.res_valid   (res.valid),
	.res_ready   (res.ready),
	.lamp_bits   (res.lamp_bits),
	.plane       (res.plane),
	.frame_start (res.frame_start)
);
